[rtl/adfp_pkg.sv]
// package for the delimited ascii decimal frame parser: sizes, framing bytes, shared types
`default_nettype none
package adfp_pkg;

	localparam int FIELDS    = 6;
	localparam int DIGITS    = 3;
	localparam int STORE_LEN = FIELDS * DIGITS;
	localparam int ADDR_W    = (STORE_LEN > 1) ? $clog2(STORE_LEN) : 1;
	localparam int DIG_W     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int FLD_W     = 4;

	localparam logic [7:0] CH_START = 8'h23;
	localparam logic [7:0] CH_END   = 8'h24;
	localparam logic [7:0] CH_SEP   = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// tag that travels with one store read
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             last;
		logic [FLD_W-1:0] fidx;
		logic             flast;
	} rd_tag_t;

endpackage
`default_nettype wire

[rtl/ascii_decimal_frame_parser_core.sv]
// Top level of the delimited ascii decimal frame parser.
//
// Input channel: rx_byte with in_valid / in_stall, one received byte per
// transfer. '#' opens a frame, data bytes are stored, ',' checks the group
// length, '$' with a full store starts the conversion.
// Output channel: field_index, field_value, last_field with out_valid /
// out_stall, one decoded field per transfer, last_field on the final one.
// Configuration: cfg_write with cfg_data sets ascii_mode (reset value 1).
//
// Every byte other than a completing '$' is accepted without a stall. A
// completing '$' raises in_stall while the store is walked one byte per cycle
// through its single read port, except that a field's final digit is read only
// when the output register can take it. Each read byte is registered with its
// tag, accumulated, and a field's final digit loads the sum into the output
// register. While out_stall is high the field in the output register holds and
// the walk pauses before the next field's final digit is read.
// Reset clears the framing state, the counters and the output valid and
// sets ascii_mode; the byte store needs no clearing.
`default_nettype none
module ascii_decimal_frame_parser_core
	import adfp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write,
	input  wire logic             cfg_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       rx_byte,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [FLD_W-1:0] field_index,
	output logic      [15:0]      field_value,
	output logic                  last_field
);

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	rd_tag_t           rd_tag;
	logic              out_free;

	adfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.out_free (out_free),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_tag   (rd_tag)
	);

	adfp_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	adfp_conv u_conv (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.rd_tag      (rd_tag),
		.rd_data     (rd_data),
		.out_free    (out_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.field_index (field_index),
		.field_value (field_value),
		.last_field  (last_field)
	);

endmodule
`default_nettype wire

[rtl/adfp_store.sv]
// byte store: one write port, one read port with registered read data
`default_nettype none
module adfp_store
	import adfp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [7:0]        wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [7:0]        rd_data
);

	logic [7:0] mem_q [STORE_LEN];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

[rtl/adfp_ctrl.sv]
// framing state machine, byte and group counters, and store read sequencer
`default_nettype none
module adfp_ctrl
	import adfp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              out_free,
	output logic                   wr_en,
	output logic      [ADDR_W-1:0] wr_addr,
	output logic      [7:0]        wr_data,
	output logic                   rd_en,
	output logic      [ADDR_W-1:0] rd_addr,
	output rd_tag_t                rd_tag
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RECV,
		ST_CONV
	} state_t;

	state_t            state_q;
	logic [7:0]        byte_cnt_q;
	logic [7:0]        group_cnt_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [DIG_W-1:0]  dig_q;
	logic [FLD_W-1:0]  fld_q;

	logic accept;
	logic dig_last;
	logic fld_last;
	logic is_data;

	assign in_stall = (state_q == ST_CONV);
	assign accept   = in_valid && !in_stall;
	assign dig_last = (dig_q == DIG_W'(DIGITS - 1));
	assign fld_last = (fld_q == FLD_W'(FIELDS - 1));
	assign is_data  = (rx_byte != CH_END) && (rx_byte != CH_SEP);

	assign wr_en   = accept && (state_q == ST_RECV) && is_data
	                 && (byte_cnt_q < 8'(STORE_LEN));
	assign wr_addr = byte_cnt_q[ADDR_W-1:0];
	assign wr_data = rx_byte;

	// the read of a field's final digit waits until the output register can take it
	assign rd_en   = (state_q == ST_CONV) && (!dig_last || out_free);
	assign rd_addr = ptr_q;

	always_comb begin
		rd_tag       = '0;
		rd_tag.vld   = rd_en;
		rd_tag.first = (dig_q == '0);
		rd_tag.last  = dig_last;
		rd_tag.fidx  = fld_q;
		rd_tag.flast = fld_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			byte_cnt_q  <= '0;
			group_cnt_q <= '0;
			ptr_q       <= '0;
			dig_q       <= '0;
			fld_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && rx_byte == CH_START) begin
						state_q <= ST_RECV;
					end
				end
				ST_RECV: begin
					if (accept) begin
						if (rx_byte == CH_END) begin
							if (byte_cnt_q == 8'(STORE_LEN)) begin
								state_q    <= ST_CONV;
								byte_cnt_q <= '0;
								ptr_q      <= '0;
								dig_q      <= '0;
								fld_q      <= '0;
							end
						end else if (rx_byte == CH_SEP) begin
							if (group_cnt_q != 8'(DIGITS)) begin
								state_q    <= ST_IDLE;
								byte_cnt_q <= '0;
							end
							group_cnt_q <= '0;
						end else begin
							if (byte_cnt_q != 8'hFF) begin
								byte_cnt_q <= byte_cnt_q + 8'd1;
							end
							if (group_cnt_q != 8'hFF) begin
								group_cnt_q <= group_cnt_q + 8'd1;
							end
						end
					end
				end
				ST_CONV: begin
					if (rd_en) begin
						ptr_q <= ptr_q + ADDR_W'(1);
						if (dig_last) begin
							dig_q <= '0;
							fld_q <= fld_q + FLD_W'(1);
							if (fld_last) begin
								state_q <= ST_IDLE;
							end
						end else begin
							dig_q <= dig_q + DIG_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/adfp_conv.sv]
// digit accumulator, mode register and output register
`default_nettype none
module adfp_conv
	import adfp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write,
	input  wire logic             cfg_data,
	input  rd_tag_t               rd_tag,
	input  wire logic [7:0]       rd_data,
	output logic                  out_free,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [FLD_W-1:0] field_index,
	output logic      [15:0]      field_value,
	output logic                  last_field
);

	logic        ascii_mode_q;
	rd_tag_t     tag_s1;
	logic [15:0] acc_q;
	logic        out_valid_q;

	logic [15:0] digit;
	logic [15:0] acc_x10;
	logic [15:0] acc_next;

	// a negative ascii digit wraps modulo 2^16
	assign digit    = ascii_mode_q ? ({8'h00, rd_data} - {8'h00, CH_ZERO}) : {8'h00, rd_data};
	assign acc_x10  = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0};
	assign acc_next = (tag_s1.first ? 16'h0000 : acc_x10) + digit;

	// a finished field still in the pipeline register claims the output register next
	assign out_free  = (!out_valid_q || !out_stall) && !(tag_s1.vld && tag_s1.last);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_mode_q <= 1'b1;
			tag_s1       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				ascii_mode_q <= cfg_data;
			end
			tag_s1 <= rd_tag;
			if (tag_s1.vld && tag_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s1.vld) begin
			acc_q <= acc_next;
		end
		if (tag_s1.vld && tag_s1.last) begin
			field_index <= tag_s1.fidx;
			field_value <= acc_next;
			last_field  <= tag_s1.flast;
		end
	end

endmodule
`default_nettype wire

[test/testbench.sv]
// testbench for the ascii decimal frame parser: byte driver, field checker, frame predictor
`timescale 1ns / 1ps
module testbench;
	import adfp_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = STORE_LEN + DIGITS + 8;
	localparam int DRAIN_LIMIT   = 100000;

	typedef struct packed {
		logic [FLD_W-1:0] idx;
		logic [15:0]      value;
		logic             last;
	} field_t;

	typedef enum int {FR_GOOD, FR_BAD_GROUP, FR_EARLY_END, FR_NOISE} frame_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [FLD_W-1:0] field_index;
	logic [15:0] field_value;
	logic last_field;

	// pacing and hold-off control
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_go = 1'b0;
	logic rx_hold = 1'b0;

	logic [7:0] byte_q[$];
	field_t field_exp_q[$];
	field_t next_field;
	int err_count = 0;

	// parser state as predicted
	logic pred_mode = 1'b1;
	logic in_frame = 1'b0;
	logic [7:0] byte_cnt = 8'd0;
	logic [7:0] group_cnt = 8'd0;
	logic [7:0] digit_store [STORE_LEN];

	ascii_decimal_frame_parser_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.field_index(field_index),
		.field_value(field_value),
		.last_field (last_field)
	);

	always #2 clk = ~clk;

	task automatic flag_error(input string msg);
		if (err_count < 50)
			$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	function automatic logic [15:0] field_value_of(input int f);
		logic [31:0] acc;
		logic [31:0] dig;
		logic [31:0] scale;
		int j;
		int k;
		acc = 32'd0;
		for (j = 0; j < DIGITS; j++) begin
			dig = 32'(digit_store[f * DIGITS + j]);
			if (pred_mode)
				dig = dig - 32'(CH_ZERO);
			scale = 32'd1;
			for (k = 0; k < DIGITS - 1 - j; k++)
				scale = scale * 32'd10;
			acc = acc + dig * scale;
		end
		return acc[15:0];
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		field_t fr;
		int f;
		if (!in_frame) begin
			if (b == CH_START)
				in_frame = 1'b1;
		end else if (b == CH_END) begin
			// wrong count keeps the frame open
			if (byte_cnt == STORE_LEN) begin
				for (f = 0; f < FIELDS && f < 16; f++) begin
					fr.idx = f[FLD_W-1:0];
					fr.value = field_value_of(f);
					fr.last = (f == FIELDS - 1 || f == 15);
					field_exp_q.push_back(fr);
				end
				in_frame = 1'b0;
				byte_cnt = 8'd0;
			end
		end else if (b == CH_SEP) begin
			if (group_cnt != DIGITS) begin
				in_frame = 1'b0;
				byte_cnt = 8'd0;
			end
			group_cnt = 8'd0;
		end else begin
			if (byte_cnt < STORE_LEN)
				digit_store[byte_cnt] = b;
			if (byte_cnt != 8'hFF)
				byte_cnt = byte_cnt + 8'd1;
			if (group_cnt != 8'hFF)
				group_cnt = group_cnt + 8'd1;
		end
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			if (in_valid && !in_stall)
				parse_byte(rx_byte);
			if (!in_valid || !in_stall) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte <= byte_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// field monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (field_exp_q.size() == 0) begin
					flag_error($sformatf("field transfer with nothing expected, index %0d value %0d",
						field_index, field_value));
				end else begin
					next_field = field_exp_q.pop_front();
					if (field_index !== next_field.idx)
						flag_error($sformatf("field_index %0d, expected %0d",
							field_index, next_field.idx));
					if (field_value !== next_field.value)
						flag_error($sformatf("field_value %0d, expected %0d (index %0d)",
							field_value, next_field.value, next_field.idx));
					if (last_field !== next_field.last)
						flag_error($sformatf("last_field %0b, expected %0b (index %0d)",
							last_field, next_field.last, next_field.idx));
				end
			end
			out_stall <= rx_hold || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// long receiver hold-off so the parser backs up into its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	function automatic logic [7:0] rand_digit();
		logic [7:0] b;
		if ($urandom_range(99) < 85) begin
			b = 8'($urandom_range(9));
			if (pred_mode)
				b = b + CH_ZERO;
		end else begin
			do
				b = 8'($urandom_range(255));
			while (b == CH_SEP || b == CH_END);
		end
		return b;
	endfunction

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			byte_q.push_back(s[i]);
	endtask

	task automatic add_frame(input frame_kind_t kind, output int n);
		int start;
		int f;
		int j;
		int stop_at;
		int glen;
		logic trail;
		start = byte_q.size();
		if (kind == FR_NOISE) begin
			repeat ($urandom_range(4, 1))
				byte_q.push_back(8'($urandom_range(255)));
			// two commas always leave the parser idle
			byte_q.push_back(CH_SEP);
			byte_q.push_back(CH_SEP);
			n = 0;
		end else if (kind == FR_BAD_GROUP) begin
			byte_q.push_back(CH_START);
			stop_at = $urandom_range(FIELDS - 1);
			for (f = 0; f < stop_at; f++) begin
				for (j = 0; j < DIGITS; j++)
					byte_q.push_back(rand_digit());
				byte_q.push_back(CH_SEP);
			end
			do
				glen = $urandom_range(DIGITS + 2);
			while (glen == DIGITS);
			for (j = 0; j < glen; j++)
				byte_q.push_back(rand_digit());
			byte_q.push_back(CH_SEP);
			byte_q.push_back(CH_SEP);
			n = byte_q.size() - start;
		end else begin
			byte_q.push_back(CH_START);
			stop_at = (kind == FR_EARLY_END) ? $urandom_range(FIELDS - 1) : -1;
			trail = ($urandom_range(99) < 85);
			for (f = 0; f < FIELDS; f++) begin
				if (f == stop_at)
					byte_q.push_back(CH_END);
				for (j = 0; j < DIGITS; j++)
					byte_q.push_back(rand_digit());
				if (f < FIELDS - 1 || trail)
					byte_q.push_back(CH_SEP);
			end
			byte_q.push_back(CH_END);
			n = byte_q.size() - start;
		end
	endtask

	task automatic drain_all();
		int k;
		k = 0;
		while ((byte_q.size() != 0 || in_valid || field_exp_q.size() != 0) && k < DRAIN_LIMIT) begin
			@(negedge clk);
			k++;
		end
		if (field_exp_q.size() != 0) begin
			flag_error($sformatf("%0d expected fields never arrived", field_exp_q.size()));
			field_exp_q.delete();
		end
		// a rejected end marker leaves nothing to wait for, so settle anyway
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic mode, input int send_pct, input int recv_pct,
		input int n_items);
		int made;
		int cnt;
		int pick;
		frame_kind_t kind;
		drain_all();
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		pred_mode = mode;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		made = 0;
		while (made < n_items) begin
			pick = $urandom_range(99);
			if (pick < 65)
				kind = FR_GOOD;
			else if (pick < 77)
				kind = FR_BAD_GROUP;
			else if (pick < 89)
				kind = FR_EARLY_END;
			else
				kind = FR_NOISE;
			add_frame(kind, cnt);
			made += cnt;
		end
	endtask

	initial begin
		int i;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_phase(1'b1, 0, 0, 0);
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hFF);
		byte_q.push_back(CH_END);
		push_text("#1,");
		// start byte as data, then an end marker with too few bytes
		push_text("##00,$");
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hFF);
		push_text("9,999,000,505,123$");
		// group count survives completion, so the first comma passes
		push_text("#,,");

		run_phase(1'b0, 63, 0, 16);
		run_phase(1'b1, 0, 63, 16);
		run_phase(1'b0, 13, 13, 16);

		run_phase(1'b1, 0, 0, 0);
		hold_go = 1'b1;
		add_frame(FR_GOOD, i);
		// overlong frame: counters saturate and the store stops filling
		byte_q.push_back(CH_START);
		for (i = 0; i < 256; i++)
			byte_q.push_back(rand_digit());
		byte_q.push_back(CH_END);
		byte_q.push_back(CH_SEP);
		add_frame(FR_GOOD, i);

		drain_all();
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
